[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TLA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/tla_pkg.sv]
// Shared constants, types and codes of the tank level averager.
package tla_pkg;

	// Default ring depth
	localparam int DEPTH_DEF = 10;
	// Calibration clamp margin and sample ceiling
	localparam int MARGIN  = 10;
	localparam int ADC_MAX = 4095;

	// Field widths
	localparam int ADC_W = 12;
	localparam int LIT_W = 16;
	localparam int PROD_W = ADC_W + LIT_W;
	localparam int CFG_AW = 2;
	localparam int CFG_DW = 16;

	// Register indexes
	localparam logic [CFG_AW-1:0] REG_ADC_EMPTY    = 2'd0;
	localparam logic [CFG_AW-1:0] REG_ADC_FULL     = 2'd1;
	localparam logic [CFG_AW-1:0] REG_LITERS_EMPTY = 2'd2;
	localparam logic [CFG_AW-1:0] REG_LITERS_FULL  = 2'd3;

	// Datapath commands
	typedef enum logic [3:0] {
		OP_NONE,
		OP_STORE,
		OP_FIRST,
		OP_CONV,
		OP_DIV_LIT,
		OP_ACC,
		OP_NEXT,
		OP_DIV_LVL,
		OP_LVL,
		OP_DIV_AVG,
		OP_AVG,
		OP_OUT
	} op_t;

	// Datapath status toward the controller
	typedef struct packed {
		logic interp;
		logic last;
		logic div_done;
		logic wrapped;
		logic out_free;
	} stat_t;

endpackage

[rtl/tla_div.sv]
// Restoring divider, one quotient bit per cycle.
module tla_div #(
	parameter int DW = 28,
	parameter int VW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int NW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [NW-1:0] cnt_q;
	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [VW:0]   sh;
	logic [VW:0]   diff;
	logic          ge;

	// Trial subtract of the shifted remainder
	assign sh   = {rem_q, quo_q[DW-1]};
	assign ge   = sh >= {1'b0, divisor};
	assign diff = sh - {1'b0, divisor};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= NW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - NW'(1);
			if (cnt_q == NW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[VW-1:0] : sh[VW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

[rtl/tla_dp.sv]
// Datapath: configuration, sample ring, calibration, sums and result register.
module tla_dp #(
	parameter int DEPTH = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tla_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic [tla_pkg::CFG_DW-1:0]    cfg_wdata,
	input  logic                          in_xfer,
	input  logic [tla_pkg::ADC_W-1:0]     in_sample,
	input  tla_pkg::op_t                  op,
	output tla_pkg::stat_t                stat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tla_pkg::LIT_W-1:0]     level_liters,
	output logic                          cal_fault,
	output logic [tla_pkg::ADC_W-1:0]     adc_average,
	output logic                          tank_empty
);
	import tla_pkg::*;

	localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int LSW = $clog2(DEPTH * 131071 + 1);
	localparam int ASW = $clog2(DEPTH * 4095 + 1);
	// Reciprocal of DEPTH, exact for any sum below 2**LSW
	localparam int RSH = LSW + $clog2(DEPTH);
	localparam longint RECIP_L = ((longint'(1) << RSH) + longint'(DEPTH) - 1) / DEPTH;
	localparam logic [LSW:0] RECIP = (LSW+1)'(RECIP_L);

	logic [ADC_W-1:0]  adc_empty_q, adc_full_q;
	logic [LIT_W-1:0]  liters_empty_q, liters_full_q;
	logic [ADC_W-1:0]  ring_q [DEPTH];
	logic [ADC_W-1:0]  rdata_q, sample_q;
	logic [CW-1:0]     fill_q;
	logic              wrapped_q;
	logic [IW-1:0]     idx_q, wr_idx;
	logic [LSW-1:0]    lsum_q;
	logic [ASW-1:0]    asum_q;
	logic              err_q;
	logic [PROD_W-1:0] prod_q;
	logic [2*LSW:0]    rprod_q;
	logic [LSW-1:0]    rquot;
	logic [LIT_W-1:0]  level_q;
	logic [ADC_W-1:0]  avg_q;
	logic [CW-1:0]     count;
	logic              bad, near_e, near_f;
	logic [ADC_W:0]    e_m, f_m, a_m;
	logic [LIT_W-1:0]  clamp, lspan;
	logic [ADC_W-1:0]  pos;
	logic [LIT_W:0]    lit;
	logic              div_start, div_done;
	logic [PROD_W-1:0] quot;
	logic [ADC_W-1:0]  div_divisor;
	logic              out_valid_q, out_err_q, out_empty_q;
	logic [LIT_W-1:0]  out_level_q;
	logic [ADC_W-1:0]  out_avg_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adc_empty_q    <= 12'd4000;
			adc_full_q     <= 12'd500;
			liters_empty_q <= 16'd0;
			liters_full_q  <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ADC_EMPTY:    adc_empty_q    <= cfg_wdata[ADC_W-1:0];
				REG_ADC_FULL:     adc_full_q     <= cfg_wdata[ADC_W-1:0];
				REG_LITERS_EMPTY: liters_empty_q <= cfg_wdata;
				REG_LITERS_FULL:  liters_full_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Live sample, taken on the input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) sample_q <= in_sample;
	end

	// Ring write slot: restart at zero when full
	assign wr_idx = (fill_q >= CW'(DEPTH)) ? '0 : fill_q[IW-1:0];
	assign count  = wrapped_q ? CW'(DEPTH) : fill_q;

	// Ring memory, registered read
	always_ff @(posedge clk) begin
		if (op == OP_STORE) ring_q[wr_idx] <= sample_q;
		rdata_q <= ring_q[idx_q];
	end

	// Fill count and wrap flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			wrapped_q <= 1'b0;
		end else if (op == OP_STORE) begin
			if (fill_q >= CW'(DEPTH)) begin
				wrapped_q <= 1'b1;
				fill_q    <= CW'(1);
			end else begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	// Calibration checks on the stored sample
	assign e_m    = {1'b0, adc_empty_q} + (ADC_W+1)'(MARGIN);
	assign f_m    = {1'b0, adc_full_q} + (ADC_W+1)'(MARGIN);
	assign a_m    = {1'b0, rdata_q} + (ADC_W+1)'(MARGIN);
	assign bad    = ({5'b0, rdata_q} >= 17'(ADC_MAX)) || ({1'b0, rdata_q} > e_m)
		|| (a_m < {1'b0, adc_full_q}) || (adc_empty_q <= adc_full_q);
	assign near_e = a_m > {1'b0, adc_empty_q};
	assign near_f = {1'b0, rdata_q} < f_m;
	assign clamp  = near_e ? liters_empty_q : liters_full_q;
	assign lspan  = (liters_full_q >= liters_empty_q) ? liters_full_q - liters_empty_q
		: liters_empty_q - liters_full_q;
	assign pos    = adc_empty_q - rdata_q;
	assign lit    = {1'b0, liters_empty_q} + quot[LIT_W:0];

	// Quotient of the registered reciprocal product
	assign rquot  = LSW'(rprod_q >> RSH);

	// Accumulators and loop index
	always_ff @(posedge clk) begin
		case (op)
			OP_FIRST: begin
				idx_q  <= '0;
				lsum_q <= '0;
				asum_q <= '0;
				err_q  <= 1'b0;
			end
			OP_CONV: begin
				asum_q <= asum_q + ASW'(rdata_q);
				prod_q <= pos * lspan;
				if (!err_q) begin
					if (bad) err_q <= 1'b1;
					else if (near_e || near_f) lsum_q <= lsum_q + LSW'(clamp);
				end
			end
			OP_ACC: begin
				if (lit == '0) err_q <= 1'b1;
				else lsum_q <= lsum_q + LSW'(lit);
			end
			OP_NEXT:    idx_q <= idx_q + IW'(1);
			OP_DIV_LVL: rprod_q <= lsum_q * RECIP;
			OP_LVL:     level_q <= (|rquot[LSW-1:LIT_W]) ? '1 : rquot[LIT_W-1:0];
			OP_DIV_AVG: rprod_q <= LSW'(asum_q) * RECIP;
			OP_AVG:     avg_q <= rquot[ADC_W-1:0];
			default: ;
		endcase
	end

	// Interpolation divider
	assign div_start   = op == OP_DIV_LIT;
	assign div_divisor = adc_empty_q - adc_full_q;

	tla_div #(.DW(PROD_W), .VW(ADC_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (quot)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (op == OP_OUT) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (op == OP_OUT) begin
			out_level_q <= err_q ? '0 : level_q;
			out_err_q   <= err_q;
			out_avg_q   <= wrapped_q ? avg_q : adc_empty_q;
			out_empty_q <= {1'b0, sample_q} > e_m;
		end
	end

	assign stat.interp   = !err_q && !bad && !near_e && !near_f;
	assign stat.last     = CW'(idx_q) == count - CW'(1);
	assign stat.div_done = div_done;
	assign stat.wrapped  = wrapped_q;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign level_liters = out_level_q;
	assign cal_fault    = out_err_q;
	assign adc_average  = out_avg_q;
	assign tank_empty   = out_empty_q;
endmodule

[rtl/tla_ctrl.sv]
// Controller: sequences store, per-entry conversion and the final means.
module tla_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_xfer,
	output logic           in_ready,
	input  tla_pkg::stat_t stat,
	output tla_pkg::op_t   op
);
	import tla_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_STORE, S_FIRST, S_RDW, S_CONV, S_DIVS, S_DIVW, S_ACC,
		S_NEXT, S_LDS, S_LVL, S_ADS, S_AVG, S_OUTW
	} state_t;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// Next state and command
	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		case (state_q)
			S_IDLE:  if (in_xfer) state_d = S_STORE;
			S_STORE: begin
				op      = OP_STORE;
				state_d = S_FIRST;
			end
			S_FIRST: begin
				op      = OP_FIRST;
				state_d = S_RDW;
			end
			S_RDW:   state_d = S_CONV;
			S_CONV: begin
				op = OP_CONV;
				if (stat.interp) state_d = S_DIVS;
				else if (stat.last) state_d = S_LDS;
				else state_d = S_NEXT;
			end
			S_DIVS: begin
				op      = OP_DIV_LIT;
				state_d = S_DIVW;
			end
			S_DIVW:  if (stat.div_done) state_d = S_ACC;
			S_ACC: begin
				op      = OP_ACC;
				state_d = stat.last ? S_LDS : S_NEXT;
			end
			S_NEXT: begin
				op      = OP_NEXT;
				state_d = S_RDW;
			end
			S_LDS: begin
				op      = OP_DIV_LVL;
				state_d = S_LVL;
			end
			S_LVL: begin
				op      = OP_LVL;
				state_d = stat.wrapped ? S_ADS : S_OUTW;
			end
			S_ADS: begin
				op      = OP_DIV_AVG;
				state_d = S_AVG;
			end
			S_AVG: begin
				op      = OP_AVG;
				state_d = S_OUTW;
			end
			S_OUTW: begin
				if (stat.out_free) begin
					op      = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready = state_q == S_IDLE;
endmodule

[rtl/tank_level_averager.sv]
// Each of the N stored entries is converted in turn before the result is valid; K interpolated entries
// use a 28-bit bit-serial divide. Means use a reciprocal multiply; the sample average only once wrapped.
// One item at a time; the next item is taken while the last result waits in the output register.
// Reset (arst_n low) empties the ring count, clears the wrap flag and the output valid,
// and loads the calibration registers with their default points.
module tank_level_averager #(
	parameter int DEPTH = tla_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tla_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [tla_pkg::CFG_DW-1:0] cfg_wdata,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [15:0]                s_axis_tdata,  // [11:0] adc_sample
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// [15:0] level_liters, [16] cal_fault, [28:17] adc_average, [29] tank_empty
	output logic [31:0]                m_axis_tdata
);
	import tla_pkg::*;

	op_t              op;
	stat_t            stat;
	logic             in_xfer;
	logic [LIT_W-1:0] level_liters;
	logic             cal_fault, tank_empty;
	logic [ADC_W-1:0] adc_average;

	assign in_xfer = s_axis_tvalid && s_axis_tready;

	tla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_xfer  (in_xfer),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.op       (op)
	);

	tla_dp #(.DEPTH(DEPTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.in_xfer      (in_xfer),
		.in_sample    (s_axis_tdata[ADC_W-1:0]),
		.op           (op),
		.stat         (stat),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.level_liters (level_liters),
		.cal_fault    (cal_fault),
		.adc_average  (adc_average),
		.tank_empty   (tank_empty)
	);

	// Result packing
	assign m_axis_tdata = {2'b00, tank_empty, adc_average, cal_fault, level_liters};
endmodule

[rtl/tla_checker.sv]
// Port-level checker for the tank level averager, with its bind.
`include "assert_macros.svh"

module tla_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);
	// A stalled result stays offered
	`TLA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
	// A stalled result keeps its payload
	`TLA_ASSERT_NEXT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")
	// After taking a sample the block is busy
	`TLA_ASSERT_NEXT(a_busy, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second sample taken during processing")
	// A failed conversion reports zero liters
	`TLA_ASSERT_NOW(a_err_zero, clk, arst_n, m_axis_tvalid && m_axis_tdata[16], m_axis_tdata[15:0] == 16'd0, "nonzero level with error flag")
endmodule

bind tank_level_averager tla_checker u_tla_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

[test/testbench.sv]
// Testbench of the tank level averager: streamed samples, calibration phases, scoreboard.
`timescale 1ns / 100ps

module testbench;
	import tla_pkg::*;

	localparam int RING_N = DEPTH_DEF;

	typedef struct {
		logic [LIT_W-1:0] liters;
		logic             err;
		logic [ADC_W-1:0] avg;
		logic             empty;
	} level_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = REG_ADC_EMPTY;
	logic [CFG_DW-1:0] cfg_wdata = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [15:0]       s_axis_tdata = '0;   // [11:0] adc_sample
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	// [15:0] level_liters, [16] cal_fault, [28:17] adc_average, [29] tank_empty
	logic [31:0]       m_axis_tdata;

	// calibration and ring copy
	int unsigned cal_e, cal_f, cal_le, cal_lf;
	logic [ADC_W-1:0] ring [RING_N];
	int unsigned fill_cnt;
	bit ring_wrapped;

	logic [ADC_W-1:0] sample_q [$];
	level_t level_q [$];
	int mismatches;
	bit in_taken;
	int burst_left, gap_left;
	bit hold_req, hold_done;
	int hold_left, stall_mode, stall_cnt;

	tank_level_averager DUT (.*);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// one sample through the calibration; returns 1 on a conversion error
	function automatic bit cal_fails(input int unsigned a, output int unsigned lit);
		int unsigned span, lspan, pos, res;
		lit = 0;
		if (a >= ADC_MAX) return 1'b1;
		if (a > cal_e + MARGIN || a + MARGIN < cal_f) return 1'b1;
		if (cal_e <= cal_f) return 1'b1;
		span = cal_e - cal_f;
		lspan = (cal_lf >= cal_le) ? cal_lf - cal_le : cal_le - cal_lf;
		if (a + MARGIN > cal_e) begin
			lit = cal_le;
			return 1'b0;
		end
		if (a < cal_f + MARGIN) begin
			lit = cal_lf;
			return 1'b0;
		end
		pos = span - ((a >= cal_f) ? a - cal_f : 0);
		res = cal_le + (pos * lspan) / span;
		if (res == 0) return 1'b1;
		lit = res;
		return 1'b0;
	endfunction

	// store a sample and work out the level it reports
	function automatic level_t level_of(input logic [ADC_W-1:0] smp);
		level_t r;
		int unsigned cnt, sum, lit, asum;
		bit err;
		if (fill_cnt >= RING_N) begin
			ring_wrapped = 1'b1;
			fill_cnt = 0;
		end
		ring[fill_cnt] = smp;
		fill_cnt++;
		cnt = ring_wrapped ? RING_N : fill_cnt;
		sum = 0;
		err = 1'b0;
		for (int i = 0; i < cnt; i++) begin
			if (cal_fails(ring[i], lit)) begin
				err = 1'b1;
				break;
			end
			sum += lit;
		end
		r.err = err;
		if (err) r.liters = '0;
		else if (sum / RING_N > 32'hFFFF) r.liters = '1;
		else r.liters = LIT_W'(sum / RING_N);
		if (ring_wrapped) begin
			asum = 0;
			for (int i = 0; i < RING_N; i++) asum += ring[i];
			r.avg = ADC_W'(asum / RING_N);
		end else begin
			r.avg = ADC_W'(cal_e);
		end
		r.empty = (smp > cal_e + MARGIN);
		return r;
	endfunction

	// input transfers: predict on acceptance
	always @(posedge clk) begin
		in_taken <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready)
			level_q.push_back(level_of(s_axis_tdata[ADC_W-1:0]));
	end

	// driver: bursts with random gaps
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (sample_q.size() > 0) begin
				s_axis_tdata <= {4'b0, sample_q.pop_front()};
				s_axis_tvalid <= 1'b1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 30);
				end else begin
					burst_left--;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern plus one long hold-off
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = 3000;
		end
		if (stall_cnt == 0) begin
			stall_cnt = $urandom_range(16, 400);
			stall_mode = $urandom_range(0, 2);
		end else begin
			stall_cnt--;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// monitor: compare each output transfer with the oldest expected level
	always @(posedge clk) begin
		level_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (level_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output transfer %h", m_axis_tdata);
			end else begin
				e = level_q.pop_front();
				if (m_axis_tdata[15:0] !== e.liters || m_axis_tdata[16] !== e.err ||
				    m_axis_tdata[28:17] !== e.avg || m_axis_tdata[29] !== e.empty) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: liters %0d/%0d err %0d/%0d avg %0d/%0d empty %0d/%0d",
							e.liters, m_axis_tdata[15:0], e.err, m_axis_tdata[16],
							e.avg, m_axis_tdata[28:17], e.empty, m_axis_tdata[29]);
				end
			end
		end
	end

	task automatic set_reg(input logic [CFG_AW-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= CFG_DW'(val);
		case (idx)
			REG_ADC_EMPTY:    cal_e = val & 12'hFFF;
			REG_ADC_FULL:     cal_f = val & 12'hFFF;
			REG_LITERS_EMPTY: cal_le = val & 16'hFFFF;
			default:          cal_lf = val & 16'hFFFF;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_cal(input int unsigned e, f, le, lf);
		set_reg(REG_ADC_EMPTY, e);
		set_reg(REG_ADC_FULL, f);
		set_reg(REG_LITERS_EMPTY, le);
		set_reg(REG_LITERS_FULL, lf);
	endtask

	// sender pause: every queued sample sent and every level received
	task automatic drain();
		while (sample_q.size() > 0 || level_q.size() > 0 || s_axis_tvalid)
			@(posedge clk);
	endtask

	// mostly samples within the calibrated span, some near its ends, some anywhere
	task automatic push_random(input int n);
		int unsigned lo, hi, k;
		for (int i = 0; i < n; i++) begin
			lo = (cal_f > MARGIN) ? cal_f - MARGIN : 0;
			hi = (cal_e + MARGIN > 4095) ? 4095 : cal_e + MARGIN;
			k = $urandom_range(0, 9);
			if (k < 7 && lo <= hi) sample_q.push_back(ADC_W'($urandom_range(lo, hi)));
			else if (k < 8) sample_q.push_back(
				ADC_W'(cal_e + $urandom_range(0, 2 * MARGIN + 1) - MARGIN));
			else if (k < 9) sample_q.push_back(
				ADC_W'(cal_f + $urandom_range(0, 2 * MARGIN + 1) - MARGIN));
			else sample_q.push_back(ADC_W'($urandom_range(0, 4095)));
		end
	endtask

	initial begin
		int unsigned e, f;
		logic [ADC_W-1:0] dir_smp [20];
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: default points, clamps, edges, zero interpolation, ring wrap
		set_cal(4000, 500, 0, 100);
		dir_smp = '{12'd2000, 12'd0, 12'd4095, 12'd4094, 12'd4000, 12'd4010, 12'd4011,
			12'd3991, 12'd3990, 12'd3989, 12'd490, 12'd489, 12'd509, 12'd510,
			12'd1234, 12'd2500, 12'd3000, 12'd1000, 12'd2222, 12'd700};
		foreach (dir_smp[i])
			sample_q.push_back(dir_smp[i]);
		drain();

		// full range, widest liters
		set_cal(4095, 0, 0, 65535);
		push_random(70);
		drain();

		// inverted liters, level saturates; receiver holds off here
		set_cal(3900, 100, 65535, 0);
		hold_req = 1'b1;
		push_random(70);
		drain();

		// empty and inverted spans
		set_cal(1500, 1500, 10, 20);
		push_random(30);
		drain();
		set_cal(100, 3000, 0, 100);
		push_random(30);
		drain();

		// equal liters, then random calibrations
		set_cal(3000, 1000, 500, 500);
		push_random(60);
		drain();
		for (int p = 0; p < 5; p++) begin
			e = $urandom_range(200, 4095);
			f = $urandom_range(0, e - 100);
			set_cal(e, f, $urandom_range(0, 65535), $urandom_range(0, 65535));
			push_random(70);
			drain();
		end

		repeat (500) @(posedge clk);
		if (mismatches == 0 && level_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// run limit
	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
